// ===== design/mcc_pkg.sv =====
// ----------------------------------------------------------------------------
// mcc_pkg - shared definitions for the minimum coin change core
// Field widths, table entry layout, register codes and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package mcc_pkg;

  localparam int VALUE_W     = 10;  // target value and denomination width
  localparam int COUNT_W     = 10;  // coin count field of a table entry
  localparam int ENTRY_W     = 11;  // table entry: unreachable flag above the count
  localparam int NUM_W       = 3;   // coin_count register width
  localparam int REG_COINS   = 6;   // denomination registers in the map
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 10;

  localparam int DEF_MAX_VALUE = 1024;
  localparam int DEF_MAX_COINS = 6;

  // Register map
  localparam logic [CFG_IDX_W-1:0] CFG_COIN_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COIN_1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COIN_6     = 3'd6;

  typedef logic [ENTRY_W-1:0] entry_t;

  localparam entry_t ENTRY_UNREACH = entry_t'(1) << COUNT_W;

endpackage : mcc_pkg

`default_nettype wire

// ===== design/mcc_ifs.sv =====
// ----------------------------------------------------------------------------
// mcc_ifs - channel interfaces of the minimum coin change core
// Target input, result output and register write channels (valid/ready).
// ----------------------------------------------------------------------------
`default_nettype none

interface mcc_in_if;
  import mcc_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] target_value;
  modport source (output valid, output target_value, input ready);
  modport sink   (input valid, input target_value, output ready);
endinterface : mcc_in_if

interface mcc_out_if;
  import mcc_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] min_coins;
  logic               no_solution;
  modport source (output valid, output min_coins, output no_solution, input ready);
  modport sink   (input valid, input min_coins, input no_solution, output ready);
endinterface : mcc_out_if

interface mcc_cfg_if;
  import mcc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface : mcc_cfg_if

`default_nettype wire

// ===== design/min_coin_change_core.sv =====
// ----------------------------------------------------------------------------
// min_coin_change_core - fewest coins summing exactly to a target value
// Bottom-up table of best counts rebuilt per target in a RAM with one write and one read port.
// ----------------------------------------------------------------------------
// Sequence: for a target T in 1..MAX_VALUE-1 with n coins in use, the table is
//   rebuilt amount by amount up to T (n reads and one write-back per amount); a
//   zero or out-of-range target goes straight to the result; a result waits while the output is held.
// Flow: one target at a time; the next transfer is taken the cycle after
//   the result is loaded into the output register.
// Reset: synchronous, active low; one coin of value one; table RAM not cleared.
`default_nettype none

module min_coin_change_core #(
  parameter int MAX_VALUE = mcc_pkg::DEF_MAX_VALUE,
  parameter int MAX_COINS = mcc_pkg::DEF_MAX_COINS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mcc_in_if.sink     in_ch,
  mcc_out_if.source  out_ch,
  mcc_cfg_if.sink    cfg_ch
);
  import mcc_pkg::*;

  localparam int AW   = $clog2(MAX_VALUE);
  localparam int NREG = (MAX_COINS < REG_COINS) ? MAX_COINS : REG_COINS;
  localparam int KW   = (NREG > 1) ? $clog2(NREG) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ISSUE,
    ST_WRITE,
    ST_DONE
  } state_t;

  state_t               state_r;
  logic [NUM_W-1:0]     coin_count_r;
  logic [VALUE_W-1:0]   coin_r [NREG];
  logic [NUM_W-1:0]     n_r;
  logic [AW-1:0]        tgt_r;
  logic [AW-1:0]        v_r;
  logic [KW-1:0]        k_r;
  entry_t               best_r;
  logic                 rd_pend_r;
  entry_t               rd_data_r;
  logic [COUNT_W-1:0]   res_count_r;
  logic                 res_none_r;
  logic                 out_valid_r;
  logic [COUNT_W-1:0]   out_count_r;
  logic                 out_none_r;

  // Best count table
  entry_t               mem [MAX_VALUE];

  // ---------------------------------------------------------------------
  // Register writes: coin_count and the denominations. Indices past the
  // map, or past the coins this build can use, are dropped.
  // ---------------------------------------------------------------------
  logic [CFG_IDX_W-1:0] cfg_slot;
  assign cfg_slot     = cfg_ch.idx - CFG_COIN_1;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coin_count_r <= NUM_W'(1);
      for (int i = 0; i < NREG; i++) coin_r[i] <= VALUE_W'(1);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.idx) inside
        CFG_COIN_COUNT: coin_count_r <= cfg_ch.data[NUM_W-1:0];
        [CFG_COIN_1:CFG_COIN_6]: begin
          if (32'(cfg_slot) < NREG) coin_r[KW'(cfg_slot)] <= cfg_ch.data[VALUE_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input decode: saturate the coin count, range-check the target
  // ---------------------------------------------------------------------
  logic [NUM_W-1:0] n_sat;
  logic [31:0]      tgt32;
  logic             tgt_in_range;
  logic             in_xfer;

  always_comb begin
    n_sat = coin_count_r;
    if (n_sat > NUM_W'(NREG)) n_sat = NUM_W'(NREG);
  end

  assign tgt32        = 32'(in_ch.target_value);
  assign tgt_in_range = tgt32 < 32'(MAX_VALUE);
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;

  // ---------------------------------------------------------------------
  // Read issue: one coin per cycle, address v - c where the coin fits
  // ---------------------------------------------------------------------
  logic [VALUE_W-1:0] coin_sel;
  logic [31:0]        diff32;
  logic               issue_ok;
  logic               last_coin;
  logic [AW-1:0]      rd_addr;

  assign coin_sel  = coin_r[k_r];
  assign diff32    = 32'(v_r) - 32'(coin_sel);
  assign issue_ok  = (coin_sel != '0) && (32'(coin_sel) <= 32'(v_r));
  assign rd_addr   = diff32[AW-1:0];
  assign last_coin = (NUM_W'(k_r) == n_r - NUM_W'(1));

  // ---------------------------------------------------------------------
  // Merge: fold the returning entry into the running best for this amount
  // ---------------------------------------------------------------------
  entry_t cand;
  entry_t best_m;
  logic   pend_ok;

  assign pend_ok = rd_pend_r && !rd_data_r[COUNT_W];
  assign cand    = {1'b0, rd_data_r[COUNT_W-1:0] + COUNT_W'(1)};
  assign best_m  = (pend_ok && (best_r[COUNT_W] || (cand < best_r))) ? cand : best_r;

  // ---------------------------------------------------------------------
  // Table RAM: the entry for zero in INIT, each amount's best in WRITE.
  // An amount's reads start only after the previous write, so no
  // read-during-write case arises.
  // ---------------------------------------------------------------------
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  assign wr_en   = (state_r == ST_INIT) || (state_r == ST_WRITE);
  assign wr_addr = (state_r == ST_INIT) ? '0 : v_r;
  assign wr_data = (state_r == ST_INIT) ? '0 : best_m;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  // ---------------------------------------------------------------------
  // Sequencer and output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // flag a read whose data returns next cycle
      rd_pend_r <= (state_r == ST_ISSUE) && issue_ok;
      // drop the result once the sink has taken it
      if (out_valid_r && out_ch.ready && (state_r != ST_DONE)) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            n_r   <= n_sat;
            tgt_r <= tgt32[AW-1:0];
            if (in_ch.target_value == '0) begin
              res_count_r <= '0;
              res_none_r  <= 1'b0;
              state_r     <= ST_DONE;
            end else if (!tgt_in_range) begin
              res_count_r <= '0;
              res_none_r  <= 1'b1;
              state_r     <= ST_DONE;
            end else begin
              state_r <= ST_INIT;
            end
          end
        end
        ST_INIT: begin
          v_r     <= AW'(1);
          k_r     <= '0;
          best_r  <= ENTRY_UNREACH;
          state_r <= (n_r == '0) ? ST_WRITE : ST_ISSUE;
        end
        ST_ISSUE: begin
          best_r    <= best_m;
          if (last_coin) begin
            state_r <= ST_WRITE;
          end else begin
            k_r <= k_r + KW'(1);
          end
        end
        ST_WRITE: begin
          if (v_r == tgt_r) begin
            res_none_r  <= best_m[COUNT_W];
            res_count_r <= best_m[COUNT_W] ? '0 : best_m[COUNT_W-1:0];
            state_r     <= ST_DONE;
          end else begin
            v_r     <= v_r + AW'(1);
            k_r     <= '0;
            best_r  <= ENTRY_UNREACH;
            state_r <= (n_r == '0) ? ST_WRITE : ST_ISSUE;
          end
        end
        ST_DONE: begin
          // hold until the output register is free, then load it
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_count_r <= res_count_r;
            out_none_r  <= res_none_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.min_coins   = out_count_r;
  assign out_ch.no_solution = out_none_r;

`ifndef NO_ASSERTIONS
  a_pend_from_issue: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> $past(state_r == ST_ISSUE))
    else $error("read pending without an issue cycle");

  a_coin_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ISSUE) |-> (NUM_W'(k_r) < n_r))
    else $error("coin index beyond the coins in use");

  a_write_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |-> ((v_r <= tgt_r) && (v_r != '0)))
    else $error("table write outside one to target");

  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_WRITE) && (v_r == tgt_r)) |=> (state_r == ST_DONE))
    else $error("last amount written but no result");
`endif

endmodule : min_coin_change_core

`default_nettype wire

// ===== tb/min_coin_change_core_test.sv =====
// ----------------------------------------------------------------------------
// min_coin_change_core_test - self-checking bench for the coin change core
// Drives target values through the valid/ready channels under several coin
// register settings and checks each result against a bottom-up table model
// kept inside the bench. Covers the default coins, non-greedy sets,
// unreachable targets, zero denominations, coin count limits, writes to an
// unmapped register, random traffic with changing idle patterns, and a long
// output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module min_coin_change_core_test;
  import mcc_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;  // above the worst case of a full table build
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_OFF_LEN   = 400;
  localparam int RANDOM_ITEMS   = 26;     // per idle phase
  localparam int RECONFIG_EVERY = 11;

  // Index just past the register map; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = CFG_COIN_6 + 3'd1;

  typedef struct packed {
    logic [COUNT_W-1:0] min_coins;
    logic               no_solution;
  } coin_answer_t;

  logic clk;
  logic rst_n;

  mcc_in_if  in_ch ();
  mcc_out_if out_ch ();
  mcc_cfg_if cfg_ch ();

  min_coin_change_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Bench copy of the coin registers and the best-count table
  logic [NUM_W-1:0]   coin_limit_reg;
  logic [VALUE_W-1:0] denom_reg [REG_COINS];
  entry_t             best_tab  [DEF_MAX_VALUE];

  coin_answer_t coin_answer_q [$];
  int           error_count   = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           stall_request = 0;
  int           quiet_cycles  = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction: rebuild the table from zero up to the target, trying every
  // coin in use at every amount. Bit COUNT_W of an entry marks it unreachable.
  // --------------------------------------------------------------------------
  function automatic coin_answer_t fewest_coins(input logic [VALUE_W-1:0] amount);
    int           n_used;
    int           cand;
    logic [VALUE_W-1:0] denom;
    entry_t       best;
    entry_t       sub;
    coin_answer_t answer;
    n_used = coin_limit_reg;
    if (n_used > REG_COINS) n_used = REG_COINS;
    if (n_used > DEF_MAX_COINS) n_used = DEF_MAX_COINS;
    best_tab[0] = '0;
    for (int v = 1; v <= amount; v++) begin
      best = ENTRY_UNREACH;
      for (int k = 0; k < n_used; k++) begin
        denom = denom_reg[k];
        // a zero coin never helps, so skip it
        if (denom != 0 && denom <= v) begin
          sub = best_tab[v - denom];
          if (!sub[COUNT_W]) begin
            cand = sub[COUNT_W-1:0] + 1;
            if (best[COUNT_W] || cand < best) best = entry_t'(cand);
          end
        end
      end
      best_tab[v] = best;
    end
    if (best_tab[amount][COUNT_W]) begin
      answer.min_coins   = '0;
      answer.no_solution = 1'b1;
    end else begin
      answer.min_coins   = best_tab[amount][COUNT_W-1:0];
      answer.no_solution = 1'b0;
    end
    return answer;
  endfunction

  // --------------------------------------------------------------------------
  // Register write: hold valid until the transfer, then update the bench copy.
  // Only called while nothing is in flight.
  // --------------------------------------------------------------------------
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_COIN_COUNT) begin
      coin_limit_reg = data[NUM_W-1:0];
    end else if (idx >= CFG_COIN_1 && idx <= CFG_COIN_6) begin
      denom_reg[idx - CFG_COIN_1] = data[VALUE_W-1:0];
    end
    // an index past the map leaves every register as it was
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_coins(input int count, input int c1, input int c2, input int c3,
                            input int c4, input int c5, input int c6);
    write_register(CFG_COIN_COUNT, CFG_DATA_W'(count));
    write_register(CFG_COIN_1,         CFG_DATA_W'(c1));
    write_register(CFG_COIN_1 + 3'd1,  CFG_DATA_W'(c2));
    write_register(CFG_COIN_1 + 3'd2,  CFG_DATA_W'(c3));
    write_register(CFG_COIN_1 + 3'd3,  CFG_DATA_W'(c4));
    write_register(CFG_COIN_1 + 3'd4,  CFG_DATA_W'(c5));
    write_register(CFG_COIN_6,         CFG_DATA_W'(c6));
  endtask

  // --------------------------------------------------------------------------
  // Target transfer. Valid stays high after a transfer so that back-to-back
  // items go out without a gap; it is dropped only while idling or draining.
  // --------------------------------------------------------------------------
  task automatic send_target(input logic [VALUE_W-1:0] amount);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid        <= 1'b0;
      in_ch.target_value <= VALUE_W'($urandom);
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.target_value <= amount;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    coin_answer_q.push_back(fewest_coins(amount));
  endtask

  // Drop valid and wait until every expected result has been taken
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (coin_answer_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_target();
    int roll;
    roll = $urandom_range(99);
    if (roll < 80) return VALUE_W'($urandom_range(63));
    if (roll < 95) return VALUE_W'($urandom_range(255, 64));
    return VALUE_W'($urandom_range(1023, 256));
  endfunction

  function automatic int pick_denomination();
    case ($urandom_range(9))
      0:       return 0;
      1:       return $urandom_range(1023, 1);
      default: return $urandom_range(12, 1);
    endcase
  endfunction

  task automatic load_random_coins();
    int count;
    logic [CFG_DATA_W-1:0] raw;
    // mostly a legal count, now and then zero or one past the limit
    if ($urandom_range(9) == 0) count = $urandom_range(1) ? 7 : 0;
    else count = $urandom_range(6, 1);
    // upper data bits of the count write are don't-care; toggle them anyway
    raw = CFG_DATA_W'($urandom);
    raw[NUM_W-1:0] = NUM_W'(count);
    write_register(CFG_COIN_COUNT, raw);
    for (int k = 0; k < REG_COINS; k++)
      write_register(CFG_COIN_1 + CFG_IDX_W'(k), CFG_DATA_W'(pick_denomination()));
    if ($urandom_range(3) == 0) write_register(CFG_UNMAPPED, CFG_DATA_W'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Out of reset: one coin of value one, so every target is its own count
  task automatic test_reset_defaults();
    send_target(10'd0);
    send_target(10'd1);
    send_target(10'd1023);
    drain_results();
  endtask

  // A set where the greedy choice loses: 6 = 3 + 3, not 4 + 1 + 1
  task automatic test_non_greedy_set();
    load_coins(3, 4, 3, 1, 1023, 1023, 1023);
    send_target(10'd6);
    send_target(10'd7);
    send_target(10'd0);
    send_target(10'd18);
    drain_results();
  endtask

  // Even coins only: odd targets have no solution
  task automatic test_unreachable_targets();
    load_coins(2, 4, 6, 1, 1, 1, 1);
    send_target(10'd1);
    send_target(10'd5);
    send_target(10'd7);
    send_target(10'd10);
    send_target(10'd0);
    drain_results();
  endtask

  // A zero coin in use must be ignored
  task automatic test_zero_denomination();
    load_coins(2, 0, 3, 1, 1, 1, 1);
    send_target(10'd9);
    send_target(10'd10);
    drain_results();
  endtask

  // Count of zero leaves no coin; a count of seven saturates to six
  task automatic test_coin_count_limits();
    write_register(CFG_COIN_COUNT, CFG_DATA_W'(0));
    send_target(10'd0);
    send_target(10'd5);
    drain_results();
    // only the sixth coin fits 14, so it must be in use
    load_coins(7, 1023, 512, 256, 200, 100, 7);
    send_target(10'd14);
    send_target(10'd1023);
    drain_results();
  endtask

  // A write past the map changes nothing
  task automatic test_unmapped_register();
    write_register(CFG_UNMAPPED, 10'h3FF);
    send_target(10'd21);
    drain_results();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % RECONFIG_EVERY == 0) begin
        drain_results();
        load_random_coins();
      end
      send_target(pick_target());
    end
    drain_results();
  endtask

  // Hold the output off while targets keep coming, so the core backs up
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_coins(3, 1, 5, 10, 1, 1, 1);
    stall_request = HOLD_OFF_LEN;
    for (int k = 0; k < 6; k++) send_target(VALUE_W'($urandom_range(40)));
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a counted hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_receiver
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request != 0) begin
        hold_left     = stall_request;
        stall_request = 0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: compare each result transfer with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    coin_answer_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (coin_answer_q.size() == 0) begin
        $error("unexpected result: min_coins %0d, no_solution %0d",
               out_ch.min_coins, out_ch.no_solution);
        error_count++;
      end else begin
        want = coin_answer_q.pop_front();
        if (out_ch.min_coins !== want.min_coins) begin
          $error("min_coins: expected %0d, actual %0d", want.min_coins, out_ch.min_coins);
          error_count++;
        end
        if (out_ch.no_solution !== want.no_solution) begin
          $error("no_solution: expected %0d, actual %0d",
                 want.no_solution, out_ch.no_solution);
          error_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    // reset values of the coin registers
    coin_limit_reg = NUM_W'(1);
    for (int k = 0; k < REG_COINS; k++) denom_reg[k] = VALUE_W'(1);

    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.target_value <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.idx         <= '0;
    cfg_ch.data        <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_non_greedy_set();
    test_unreachable_targets();
    test_zero_denomination();
    test_coin_count_limits();
    test_unmapped_register();
    test_random_traffic(6, 79);
    test_random_traffic(79, 6);
    test_random_traffic(0, 0);
    test_output_backpressure();

    // drain_results has already waited out the tail
    if (coin_answer_q.size() != 0) begin
      $error("%0d results never arrived", coin_answer_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule : min_coin_change_core_test

`default_nettype wire

// ===== filelist.f =====
design/mcc_pkg.sv
design/mcc_ifs.sv
design/min_coin_change_core.sv
tb/min_coin_change_core_test.sv
